// ===== src/ctbs_pkg.sv =====
package ctbs_pkg;

  localparam logic [7:0]  NO_LINK         = 8'hFF;
  localparam logic [15:0] DEFAULT_TONE_MS = 16'd200;
  localparam int          TICK_MS         = 10;
  localparam logic [7:0]  PCT_MAX         = 8'd100;
  localparam int          HW_LEVELS       = 16;

  // Register reset values
  localparam logic [15:0] TONE_MS_RESET     = 16'd500;
  localparam logic [7:0]  BURST_TOTAL_RESET = 8'd1;
  localparam logic [15:0] GAP_MS_RESET      = 16'd0;
  localparam logic [7:0]  VOLUME_RESET      = 8'd80;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TIMER_W    = 14;

  // x / TICK_MS as (x * DIV_MUL) >> DIV_SHIFT, exact for x below 2**18
  localparam int DIV_SHIFT = 20;
  localparam int DIV_IN_W  = 17;
  localparam int DIV_PROD_W = 34;
  localparam logic [DIV_IN_W-1:0] DIV_MUL =
    DIV_IN_W'(((2 ** DIV_SHIFT) + TICK_MS - 1) / TICK_MS);

  // pct * HW_LEVELS / PCT_MAX as (pct * LEVEL_MUL) >> 8, exact for pct below PCT_MAX
  localparam int LEVEL_SHIFT = 8;
  localparam int LEVEL_PROD_W = 15;
  localparam logic [6:0] LEVEL_MUL =
    7'((HW_LEVELS * (2 ** LEVEL_SHIFT) + 100 - 1) / 100);

  typedef enum logic [2:0] {
    CMD_START      = 3'd0,
    CMD_STOP       = 3'd1,
    CMD_CONFIGURE  = 3'd2,
    CMD_UNKNOWN    = 3'd3,
    CMD_TICK       = 3'd4,
    CMD_CONNECT    = 3'd5,
    CMD_DISCONNECT = 3'd6,
    CMD_NOTIFY     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    TK_NONE     = 2'd0,
    TK_DURATION = 2'd1,
    TK_BURST    = 2'd2
  } timer_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_CUEING = 2'd1,
    ST_ERROR  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TONE_MS     = 2'd0,
    CFG_BURST_TOTAL = 2'd1,
    CFG_GAP_MS      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] link_id;
    logic       has_tone;
    logic [7:0] tone_code;
    logic       has_volume;
    logic [7:0] volume_pct;
    logic       notify_on;
  } evt_t;

  typedef struct packed {
    logic       tone_start;
    logic [2:0] tone_sel;
    logic [3:0] volume_level;
    logic       mute;
    logic       tone_stop;
    logic       status_sent;
    logic [1:0] status_code;
  } result_t;

  typedef struct packed {
    logic [7:0]         cur_tone;
    logic [7:0]         cur_volume;
    logic [7:0]         bursts_left;
    logic [TIMER_W-1:0] countdown;
    timer_kind_t        timer_kind;
    logic               playing;
    status_t            status_now;
    logic [7:0]         link_index;
    logic               notify_enabled;
  } state_t;

  typedef struct packed {
    logic room;
    logic empty;
  } fifo_stat_t;

  function automatic logic [TIMER_W-1:0] div_tick(input logic [DIV_IN_W-1:0] x);
    logic [DIV_PROD_W-1:0] prod;
    prod = DIV_PROD_W'(x) * DIV_PROD_W'(DIV_MUL);
    return prod[DIV_SHIFT +: TIMER_W];
  endfunction

  function automatic logic [3:0] level_of(input logic [7:0] pct);
    logic [LEVEL_PROD_W-1:0] prod;
    prod = LEVEL_PROD_W'(pct) * LEVEL_PROD_W'(LEVEL_MUL);
    if (pct >= PCT_MAX) begin
      return 4'(HW_LEVELS - 1);
    end
    return prod[LEVEL_SHIFT +: 4];
  endfunction

endpackage

// ===== src/ctbs_if.sv =====
interface ctbs_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] link_id;
  logic       has_tone;
  logic [7:0] tone_code;
  logic       has_volume;
  logic [7:0] volume_pct;
  logic       notify_on;

  modport source (
    output valid, cmd, link_id, has_tone, tone_code, has_volume, volume_pct, notify_on,
    input  ready
  );
  modport sink (
    input  valid, cmd, link_id, has_tone, tone_code, has_volume, volume_pct, notify_on,
    output ready
  );
endinterface

interface ctbs_res_if;
  logic       valid;
  logic       ready;
  logic       tone_start;
  logic [2:0] tone_sel;
  logic [3:0] volume_level;
  logic       mute;
  logic       tone_stop;
  logic       status_sent;
  logic [1:0] status_code;

  modport source (
    output valid, tone_start, tone_sel, volume_level, mute, tone_stop, status_sent,
           status_code,
    input  ready
  );
  modport sink (
    input  valid, tone_start, tone_sel, volume_level, mute, tone_stop, status_sent,
           status_code,
    output ready
  );
endinterface

// ===== src/ctbs_res_fifo.sv =====
module ctbs_res_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ctbs_pkg::result_t    push_data,
  ctbs_res_if.source           res,
  output ctbs_pkg::fifo_stat_t stat
);
  import ctbs_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t          entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;
  result_t          head;

  assign pop  = res.valid && res.ready;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign stat.room  = (count != CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  assign res.valid        = !stat.empty;
  assign res.tone_start   = head.tone_start;
  assign res.tone_sel     = head.tone_sel;
  assign res.volume_level = head.volume_level;
  assign res.mute         = head.mute;
  assign res.tone_stop    = head.tone_stop;
  assign res.status_sent  = head.status_sent;
  assign res.status_code  = head.status_code;

endmodule

// ===== src/cue_tone_burst_sequencer.sv =====
// Cue tone burst sequencer.
// evt carries one event request per transfer (start, stop, configure, unknown
// command, 10 ms tick, connect, disconnect, notify setting); res returns exactly
// one result request per event, in order.
// cfg_we/cfg_idx/cfg_data write tone_ms (0), burst_total (1) and gap_ms (2);
// write them only while no event is in flight. Other indexes are dropped.
// An accepted event is registered in the input register; its result is computed
// from it and pushed into the result queue, whose head is shown on res.
// Throughput: one event per cycle while the result queue has room; the only loop
// is the state update of the input register into the state and result registers.
// Timer loads (tone and gap divided by the tick) are registered from the
// config registers, one multiply by a reciprocal each.
// A two-entry result queue decouples the sides: while res stalls, the queue
// fills and the input register holds one more event, then evt.ready drops
// until res accepts a result.
// Reset (rst, synchronous) restores the register defaults (500 ms, 1 tone,
// no gap), volume 80 %, tone 0, no timer, idle status, no link, notify off,
// and empties the pipeline; evt.ready is low during reset.
module cue_tone_burst_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  ctbs_evt_if.sink                          evt,
  ctbs_res_if.source                        res,
  input  logic                              cfg_we,
  input  logic [ctbs_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [ctbs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ctbs_pkg::*;

  logic [15:0]        tone_ms;
  logic [7:0]         burst_total;
  logic [15:0]        gap_ms;
  logic [TIMER_W-1:0] burst_load;
  logic [TIMER_W-1:0] dur_load;

  logic       s1_valid;
  evt_t       s1;
  state_t     st;
  state_t     st_next;
  result_t    r;
  fifo_stat_t stat;
  logic       push;

  cmd_t       cmd;
  logic [7:0] tone_eff;
  logic [7:0] vol_eff;
  logic [2:0] sel_eff;
  logic       mute_eff;
  logic [3:0] lvl_eff;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tone_ms     <= TONE_MS_RESET;
      burst_total <= BURST_TOTAL_RESET;
      gap_ms      <= GAP_MS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        CFG_TONE_MS:     tone_ms     <= cfg_data[15:0];
        CFG_BURST_TOTAL: burst_total <= cfg_data[7:0];
        CFG_GAP_MS:      gap_ms      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Timer loads are registered from the config registers
  always_ff @(posedge clk) begin
    burst_load <= div_tick(DIV_IN_W'((tone_ms != '0) ? tone_ms : DEFAULT_TONE_MS)
                           + DIV_IN_W'(gap_ms));
    dur_load   <= div_tick(DIV_IN_W'(tone_ms));
  end

  // Input register
  assign evt.ready = !rst && (!s1_valid || stat.room);
  assign push      = s1_valid && stat.room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt.ready) begin
      s1_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      s1.cmd        <= evt.cmd;
      s1.link_id    <= evt.link_id;
      s1.has_tone   <= evt.has_tone;
      s1.tone_code  <= evt.tone_code;
      s1.has_volume <= evt.has_volume;
      s1.volume_pct <= evt.volume_pct;
      s1.notify_on  <= evt.notify_on;
    end
  end

  // Tone and volume that a tone started by this event plays with
  assign cmd      = cmd_t'(s1.cmd);
  assign tone_eff = (cmd == CMD_START && s1.has_tone) ? s1.tone_code : st.cur_tone;
  assign vol_eff  = (cmd == CMD_START && s1.has_volume) ? s1.volume_pct : st.cur_volume;
  assign sel_eff  = (tone_eff <= 8'd4) ? tone_eff[2:0] : 3'd0;
  assign mute_eff = (vol_eff == '0);
  assign lvl_eff  = mute_eff ? 4'd0 : level_of(vol_eff);

  always_comb begin
    logic    do_stop_cue;
    logic    do_stop_tone;
    logic    do_play;
    logic    arm_burst;
    logic    arm_dur;
    logic    set_status;
    status_t code;

    st_next      = st;
    r            = '0;
    do_stop_cue  = 1'b0;
    do_stop_tone = 1'b0;
    do_play      = 1'b0;
    arm_burst    = 1'b0;
    arm_dur      = 1'b0;
    set_status   = 1'b0;
    code         = ST_IDLE;

    unique case (cmd)
      CMD_START: begin
        st_next.cur_tone   = tone_eff;
        st_next.cur_volume = vol_eff;
        st_next.timer_kind = TK_NONE;
        st_next.countdown  = '0;
        do_play    = 1'b1;
        set_status = 1'b1;
        code       = ST_CUEING;
        if (burst_total > 8'd1) begin
          st_next.bursts_left = burst_total - 8'd1;
          arm_burst = 1'b1;
        end else if (tone_ms != '0) begin
          arm_dur = 1'b1;
        end
      end
      CMD_STOP: begin
        do_stop_cue = 1'b1;
      end
      CMD_CONFIGURE: begin
        st_next.cur_tone   = s1.tone_code;
        st_next.cur_volume = s1.volume_pct;
        set_status = 1'b1;
        code       = ST_IDLE;
      end
      CMD_UNKNOWN: begin
        set_status = 1'b1;
        code       = ST_ERROR;
      end
      CMD_TICK: begin
        if (st.timer_kind != TK_NONE) begin
          if (st.countdown <= TIMER_W'(1)) begin
            st_next.timer_kind = TK_NONE;
            st_next.countdown  = '0;
            if (st.timer_kind == TK_DURATION) begin
              do_stop_cue = 1'b1;
            end else begin
              // burst expiry: replay the tone if any are left
              do_stop_tone = 1'b1;
              if (st.bursts_left != '0) begin
                st_next.bursts_left = st.bursts_left - 8'd1;
                do_play = 1'b1;
                if (st.bursts_left != 8'd1) begin
                  arm_burst = 1'b1;
                end else if (tone_ms != '0) begin
                  arm_dur = 1'b1;
                end
              end else begin
                do_stop_cue = 1'b1;
              end
            end
          end else begin
            st_next.countdown = st.countdown - 1'b1;
          end
        end
      end
      CMD_CONNECT: begin
        st_next.link_index = s1.link_id;
      end
      CMD_DISCONNECT: begin
        if (s1.link_id == st.link_index) begin
          st_next.link_index     = NO_LINK;
          st_next.notify_enabled = 1'b0;
          if (st.status_now == ST_CUEING) begin
            do_stop_cue = 1'b1;
          end
        end
      end
      CMD_NOTIFY: begin
        st_next.notify_enabled = s1.notify_on;
        if (s1.notify_on && st.link_index == NO_LINK) begin
          st_next.link_index = s1.link_id;
        end
      end
      default: ;
    endcase

    if (do_stop_cue) begin
      st_next.timer_kind  = TK_NONE;
      st_next.countdown   = '0;
      st_next.bursts_left = '0;
      do_stop_tone = 1'b1;
      set_status   = 1'b1;
      code         = ST_IDLE;
    end

    // stop comes before any new tone of the same event
    if (do_stop_tone && st.playing) begin
      r.tone_stop     = 1'b1;
      st_next.playing = 1'b0;
    end

    if (do_play) begin
      r.tone_start    = 1'b1;
      r.tone_sel      = sel_eff;
      r.volume_level  = lvl_eff;
      r.mute          = mute_eff;
      st_next.playing = 1'b1;
    end

    if (arm_burst) begin
      st_next.countdown  = burst_load;
      st_next.timer_kind = TK_BURST;
    end else if (arm_dur) begin
      st_next.countdown  = dur_load;
      st_next.timer_kind = TK_DURATION;
    end

    if (set_status) begin
      st_next.status_now = code;
      if (st_next.notify_enabled && st_next.link_index != NO_LINK) begin
        r.status_sent = 1'b1;
      end
    end

    r.status_code = st_next.status_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.cur_tone       <= '0;
      st.cur_volume     <= VOLUME_RESET;
      st.bursts_left    <= '0;
      st.countdown      <= '0;
      st.timer_kind     <= TK_NONE;
      st.playing        <= 1'b0;
      st.status_now     <= ST_IDLE;
      st.link_index     <= NO_LINK;
      st.notify_enabled <= 1'b0;
    end else if (push) begin
      st <= st_next;
    end
  end

  ctbs_res_fifo u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (r),
    .res       (res),
    .stat      (stat)
  );

  a_idle_timer_clear: assert property (@(posedge clk) disable iff (rst)
    st.timer_kind == TK_NONE |-> st.countdown == '0)
    else $error("countdown left nonzero with no timer armed");

  a_status_needs_link: assert property (@(posedge clk) disable iff (rst)
    push && r.status_sent |-> st.notify_enabled && st.link_index != NO_LINK)
    else $error("status sent without link and notify");

  a_stop_needs_play: assert property (@(posedge clk) disable iff (rst)
    push && r.tone_stop |=> !st.playing || $past(r.tone_start))
    else $error("tone stop left the tone playing");

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctbs_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ctbs_evt_if evt_ch ();
  ctbs_res_if res_ch ();

  cue_tone_burst_sequencer u_dut (
    .clk      (clk),
    .rst      (rst),
    .evt      (evt_ch),
    .res      (res_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Shadow of the sequencer: registers and cue state
  logic [15:0]        tone_ms_r;
  logic [7:0]         burst_total_r;
  logic [15:0]        gap_ms_r;
  logic [7:0]         tone_q;
  logic [7:0]         vol_q;
  logic [7:0]         bursts_rem;
  logic [TIMER_W-1:0] ticks_rem;
  timer_kind_t        tmr_kind;
  logic               is_playing;
  status_t            status_q;
  logic [7:0]         link_q;
  logic               notify_q;
  result_t            outcome;

  result_t pending_results[$];
  int      mismatch_count;
  int      idle_pct;
  int      stall_left;

  function automatic void report_status(status_t code);
    status_q = code;
    if (notify_q && link_q != NO_LINK) begin
      outcome.status_sent = 1'b1;
    end
  endfunction

  function automatic void play_current();
    outcome.tone_start = 1'b1;
    outcome.tone_sel   = (tone_q <= 8'd4) ? tone_q[2:0] : 3'd0;
    if (vol_q == 8'd0) begin
      outcome.mute         = 1'b1;
      outcome.volume_level = 4'd0;
    end else begin
      outcome.mute         = 1'b0;
      outcome.volume_level = (vol_q >= PCT_MAX) ? 4'(HW_LEVELS - 1) :
                             4'((int'(vol_q) * HW_LEVELS) / int'(PCT_MAX));
    end
    is_playing = 1'b1;
  endfunction

  function automatic void silence_tone();
    if (is_playing) begin
      outcome.tone_stop = 1'b1;
      is_playing        = 1'b0;
    end
  endfunction

  function automatic void load_burst_wait();
    int d;
    d = (tone_ms_r != 16'd0) ? int'(tone_ms_r) : int'(DEFAULT_TONE_MS);
    ticks_rem = TIMER_W'((d + int'(gap_ms_r)) / TICK_MS);
    tmr_kind  = TK_BURST;
  endfunction

  function automatic void load_tone_wait();
    ticks_rem = TIMER_W'(int'(tone_ms_r) / TICK_MS);
    tmr_kind  = TK_DURATION;
  endfunction

  function automatic void begin_cue();
    tmr_kind  = TK_NONE;
    ticks_rem = '0;
    play_current();
    report_status(ST_CUEING);
    if (burst_total_r > 8'd1) begin
      bursts_rem = burst_total_r - 8'd1;
      load_burst_wait();
    end else if (tone_ms_r != 16'd0) begin
      load_tone_wait();
    end
  endfunction

  function automatic void end_cue();
    tmr_kind   = TK_NONE;
    ticks_rem  = '0;
    bursts_rem = '0;
    silence_tone();
    report_status(ST_IDLE);
  endfunction

  function automatic void on_expiry();
    timer_kind_t kind;
    kind      = tmr_kind;
    tmr_kind  = TK_NONE;
    ticks_rem = '0;
    if (kind == TK_DURATION) begin
      end_cue();
    end else begin
      silence_tone();
      if (bursts_rem != 8'd0) begin
        bursts_rem = bursts_rem - 8'd1;
        play_current();
        if (bursts_rem != 8'd0) begin
          load_burst_wait();
        end else if (tone_ms_r != 16'd0) begin
          load_tone_wait();
        end
      end else begin
        end_cue();
      end
    end
  endfunction

  function automatic result_t sequence_event(evt_t e);
    outcome = '0;
    case (cmd_t'(e.cmd))
      CMD_START: begin
        if (e.has_tone) tone_q = e.tone_code;
        if (e.has_volume) vol_q = e.volume_pct;
        begin_cue();
      end
      CMD_STOP: begin
        end_cue();
      end
      CMD_CONFIGURE: begin
        tone_q = e.tone_code;
        vol_q  = e.volume_pct;
        report_status(ST_IDLE);
      end
      CMD_UNKNOWN: begin
        report_status(ST_ERROR);
      end
      CMD_TICK: begin
        if (tmr_kind != TK_NONE) begin
          if (ticks_rem <= TIMER_W'(1)) on_expiry();
          else ticks_rem = ticks_rem - TIMER_W'(1);
        end
      end
      CMD_CONNECT: begin
        link_q = e.link_id;
      end
      CMD_DISCONNECT: begin
        if (e.link_id == link_q) begin
          link_q   = NO_LINK;
          notify_q = 1'b0;
          if (status_q == ST_CUEING) end_cue();
        end
      end
      default: begin
        notify_q = e.notify_on;
        if (e.notify_on && link_q == NO_LINK) link_q = e.link_id;
      end
    endcase
    outcome.status_code = status_q;
    return outcome;
  endfunction

  function automatic evt_t make_evt(cmd_t c, logic [7:0] lid, logic ht, logic [7:0] tc,
                                    logic hv, logic [7:0] vp, logic non);
    evt_t e;
    e.cmd        = c;
    e.link_id    = lid;
    e.has_tone   = ht;
    e.tone_code  = tc;
    e.has_volume = hv;
    e.volume_pct = vp;
    e.notify_on  = non;
    return e;
  endfunction

  function automatic evt_t rand_event();
    evt_t e;
    int   w;
    w = $urandom_range(99);
    if (w < 40) e.cmd = CMD_TICK;
    else if (w < 58) e.cmd = CMD_START;
    else if (w < 64) e.cmd = CMD_STOP;
    else if (w < 70) e.cmd = CMD_CONFIGURE;
    else if (w < 75) e.cmd = CMD_UNKNOWN;
    else if (w < 82) e.cmd = CMD_CONNECT;
    else if (w < 90) e.cmd = CMD_DISCONNECT;
    else e.cmd = CMD_NOTIFY;
    // keep link ids mostly in a small pool so disconnects hit the live link
    if ($urandom_range(3) == 0) e.link_id = 8'($urandom_range(254));
    else if ($urandom_range(3) == 3) e.link_id = 8'd254;
    else e.link_id = 8'($urandom_range(2));
    e.has_tone  = 1'($urandom_range(1));
    e.tone_code = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
    e.has_volume = 1'($urandom_range(1));
    case ($urandom_range(9))
      0: e.volume_pct = 8'd0;
      1: e.volume_pct = PCT_MAX;
      2: e.volume_pct = 8'($urandom_range(255, 100));
      default: e.volume_pct = 8'($urandom_range(99, 1));
    endcase
    e.notify_on = 1'($urandom_range(1));
    return e;
  endfunction

  // Present one request, hold it until accepted, then record its result
  task automatic post_event(evt_t e);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      evt_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    evt_ch.valid      <= 1'b1;
    evt_ch.cmd        <= e.cmd;
    evt_ch.link_id    <= e.link_id;
    evt_ch.has_tone   <= e.has_tone;
    evt_ch.tone_code  <= e.tone_code;
    evt_ch.has_volume <= e.has_volume;
    evt_ch.volume_pct <= e.volume_pct;
    evt_ch.notify_on  <= e.notify_on;
    @(posedge clk);
    while (!evt_ch.ready) @(posedge clk);
    pending_results.push_back(sequence_event(e));
  endtask

  task automatic drain_results();
    evt_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(logic [15:0] tone_ms, logic [15:0] burst_data,
                              logic [15:0] gap_ms);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_TONE_MS;
    cfg_data <= tone_ms;
    @(posedge clk);
    cfg_idx  <= CFG_BURST_TOTAL;
    cfg_data <= burst_data;
    @(posedge clk);
    cfg_idx  <= CFG_GAP_MS;
    cfg_data <= gap_ms;
    @(posedge clk);
    cfg_we <= 1'b0;
    tone_ms_r     = tone_ms;
    burst_total_r = burst_data[7:0];
    gap_ms_r      = gap_ms;
    // let the registered timer loads settle
    repeat (3) @(posedge clk);
  endtask

  task automatic test_cue_commands();
    post_event(make_evt(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    post_event(make_evt(CMD_NOTIFY, 8'd3, 1'b0, 8'd0, 1'b0, 8'd0, 1'b1));
    post_event(make_evt(CMD_CONFIGURE, 8'd0, 1'b0, 8'd4, 1'b0, 8'd100, 1'b0));
    post_event(make_evt(CMD_START, 8'd0, 1'b0, 8'd255, 1'b0, 8'd255, 1'b0));
    // new start while playing, warning tone and mute
    post_event(make_evt(CMD_START, 8'd0, 1'b1, 8'd200, 1'b1, 8'd0, 1'b0));
    post_event(make_evt(CMD_UNKNOWN, 8'd254, 1'b1, 8'd255, 1'b1, 8'd255, 1'b1));
    post_event(make_evt(CMD_TICK, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    post_event(make_evt(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    post_event(make_evt(CMD_TICK, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    post_event(make_evt(CMD_START, 8'd0, 1'b1, 8'd1, 1'b1, 8'd255, 1'b0));
    post_event(make_evt(CMD_START, 8'd0, 1'b1, 8'd2, 1'b1, 8'd99, 1'b0));
    post_event(make_evt(CMD_START, 8'd0, 1'b1, 8'd3, 1'b1, 8'd1, 1'b0));
  endtask

  task automatic test_link_rules();
    post_event(make_evt(CMD_NOTIFY, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    post_event(make_evt(CMD_CONNECT, 8'd254, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    post_event(make_evt(CMD_START, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    post_event(make_evt(CMD_NOTIFY, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b1));
    post_event(make_evt(CMD_DISCONNECT, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    // current link drops during a cue: cue stops silently
    post_event(make_evt(CMD_DISCONNECT, 8'd254, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    post_event(make_evt(CMD_CONNECT, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
  endtask

  task automatic test_timer_expiry();
    // zero loads fire on the very next tick
    program_regs(16'd5, 16'd2, 16'd0);
    post_event(make_evt(CMD_START, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    post_event(make_evt(CMD_TICK, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    post_event(make_evt(CMD_TICK, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    program_regs(16'd0, 16'd1, 16'd0);
    post_event(make_evt(CMD_START, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    post_event(make_evt(CMD_TICK, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    program_regs(16'hFFFF, 16'h00FF, 16'hFFFF);
    post_event(make_evt(CMD_START, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    post_event(make_evt(CMD_TICK, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
    post_event(make_evt(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
  endtask

  task automatic test_random_traffic();
    logic [15:0] t_ms;
    logic [15:0] b_data;
    logic [15:0] g_ms;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        t_ms = 16'd0; b_data = 16'd0; g_ms = 16'd0;
      end else if (phase == 1) begin
        t_ms = 16'hFFFF; b_data = 16'hFFFF; g_ms = 16'hFFFF;
      end else begin
        case ($urandom_range(9))
          0: t_ms = 16'd0;
          1, 2, 3: t_ms = 16'($urandom_range(9, 1));
          9: t_ms = 16'($urandom_range(65535));
          default: t_ms = 16'($urandom_range(150, 10));
        endcase
        case ($urandom_range(9))
          0: b_data[7:0] = 8'd0;
          1, 2, 3: b_data[7:0] = 8'd1;
          9: b_data[7:0] = 8'($urandom_range(255));
          default: b_data[7:0] = 8'($urandom_range(5, 2));
        endcase
        b_data[15:8] = 8'($urandom_range(255));
        case ($urandom_range(9))
          0, 1, 2, 3: g_ms = 16'd0;
          9: g_ms = 16'($urandom_range(65535));
          default: g_ms = 16'($urandom_range(60, 1));
        endcase
      end
      program_regs(t_ms, b_data, g_ms);
      for (int n = 0; n < 80; n++) begin
        if (phase == 7) begin
          idle_pct = 0;
        end else if (n % 20 == 0) begin
          case ($urandom_range(2))
            0: idle_pct = 0;
            1: idle_pct = 30;
            default: idle_pct = 60;
          endcase
        end
        // hold off until every pending result is back
        if (n == 40) drain_results();
        post_event(rand_event());
      end
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no event pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("tone_start", want.tone_start, res_ch.tone_start);
        check_field("tone_sel", want.tone_sel, res_ch.tone_sel);
        check_field("volume_level", want.volume_level, res_ch.volume_level);
        check_field("mute", want.mute, res_ch.mute);
        check_field("tone_stop", want.tone_stop, res_ch.tone_stop);
        check_field("status_sent", want.status_sent, res_ch.status_sent);
        check_field("status_code", want.status_code, res_ch.status_code);
      end
    end
  end

  // Receiver back-pressure in short bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      res_ch.ready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct / 2) begin
      stall_left = $urandom_range(3);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("** cue_tone_burst_sequencer: FAILED **");
    $finish;
  end

  initial begin
    int guard;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_TONE_MS;
    cfg_data          = '0;
    evt_ch.valid      = 1'b0;
    evt_ch.cmd        = CMD_STOP;
    evt_ch.link_id    = '0;
    evt_ch.has_tone   = 1'b0;
    evt_ch.tone_code  = '0;
    evt_ch.has_volume = 1'b0;
    evt_ch.volume_pct = '0;
    evt_ch.notify_on  = 1'b0;
    res_ch.ready      = 1'b0;
    mismatch_count    = 0;
    idle_pct          = 0;
    stall_left        = 0;

    tone_ms_r     = TONE_MS_RESET;
    burst_total_r = BURST_TOTAL_RESET;
    gap_ms_r      = GAP_MS_RESET;
    tone_q        = 8'd0;
    vol_q         = VOLUME_RESET;
    bursts_rem    = 8'd0;
    ticks_rem     = '0;
    tmr_kind      = TK_NONE;
    is_playing    = 1'b0;
    status_q      = ST_IDLE;
    link_q        = NO_LINK;
    notify_q      = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 30;
    test_cue_commands();
    test_link_rules();
    test_timer_expiry();
    test_random_traffic();

    evt_ch.valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 2000) begin
      guard++;
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("** cue_tone_burst_sequencer: PASSED **");
    end else begin
      $display("** cue_tone_burst_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
